[hw/rtl/dtok_pkg.sv]
package dtok_pkg;

    localparam int unsigned CP_W = 22;

    localparam logic [7:0] MARK_OPEN  = 8'h3C;
    localparam logic [7:0] MARK_BAR   = 8'h7C;
    localparam logic [7:0] LEAD_TWO   = 8'h80;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] LEAD_FOUR  = 8'hF0;
    localparam logic [7:0] LEAD_MASK  = 8'h7F;
    localparam logic [7:0] TRAIL_MASK = 8'h3F;
    localparam logic [7:0] MIN_SPECIAL_LEN = 8'd4;

    // Candidate code points produced by one input word, in output order
    typedef struct packed {
        logic [CP_W-1:0] p0;
        logic            v0;
        logic [CP_W-1:0] p1;
        logic            v1;
    } entry_t;

    typedef struct packed {
        logic full;
        logic avail;
    } q_stat_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] raw;
    } unmap_t;

    // Inverse byte-to-unicode table
    function automatic unmap_t unmap_point(input logic [CP_W-1:0] cp);
        unmap_t     r;
        logic       hi_zero;
        logic [8:0] low9;
        logic [8:0] diff;
        hi_zero = (cp[CP_W-1:9] == '0);
        low9    = cp[8:0];
        diff    = low9 - 9'd162;
        r.ok    = 1'b0;
        r.raw   = cp[7:0];
        if (hi_zero)
        begin
            if ((low9 >= 9'd33 && low9 <= 9'd126) || (low9 >= 9'd161 && low9 <= 9'd172) ||
                (low9 >= 9'd174 && low9 <= 9'd288))
            begin
                r.ok  = 1'b1;
                r.raw = cp[7:0];
            end
            else if (low9 >= 9'd289 && low9 <= 9'd322)
            begin
                r.ok  = 1'b1;
                r.raw = diff[7:0];
            end
            else if (low9 == 9'd323)
            begin
                r.ok  = 1'b1;
                r.raw = 8'd173;
            end
        end
        return r;
    endfunction

endpackage

[hw/rtl/dtok_in_if.sv]
interface dtok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       token_start;
    logic       token_end;
    logic [7:0] token_length;

    modport source (output valid, text_byte, token_start, token_end, token_length,
                    input ready);
    modport sink (input valid, text_byte, token_start, token_end, token_length,
                  output ready);
endinterface

[hw/rtl/dtok_out_if.sv]
interface dtok_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, out_byte, run_last, input ready);
    modport sink (input valid, out_byte, run_last, output ready);
endinterface

[hw/rtl/dtok_front.sv]
module dtok_front (
    input  logic              clk,
    input  logic              rst_n,
    dtok_in_if.sink           text_in,
    input  dtok_pkg::q_stat_t q_stat,
    output logic              push,
    output dtok_pkg::entry_t  push_data
);
    import dtok_pkg::*;

    logic [CP_W-1:0] acc_reg, acc_next;
    logic [1:0]      bse_reg, bse_next;
    logic            skip_reg, skip_next;
    logic            hold_reg, hold_next;
    logic            accept;
    logic            do_dec;
    logic [7:0]      b;
    logic [1:0]      n;
    entry_t          e;

    assign text_in.ready = !q_stat.full;
    assign accept        = text_in.valid && text_in.ready;
    assign b             = text_in.text_byte;

    always_comb
    begin
        acc_next  = acc_reg;
        bse_next  = bse_reg;
        skip_next = skip_reg;
        hold_next = hold_reg;
        e         = '0;
        do_dec    = 1'b0;
        n         = 2'd1;

        // close the previous token
        if (text_in.token_start)
        begin
            if (hold_next)
            begin
                e.p0 = CP_W'(MARK_OPEN);
                e.v0 = 1'b1;
            end
            hold_next = 1'b0;
            skip_next = 1'b0;
            if (bse_next != 2'd0)
            begin
                if (!e.v0)
                begin
                    e.p0 = acc_next;
                    e.v0 = 1'b1;
                end
                else
                begin
                    e.p1 = acc_next;
                    e.v1 = 1'b1;
                end
                bse_next = 2'd0;
                acc_next = '0;
            end
        end

        if (skip_next)
        begin
            if (text_in.token_end)
                skip_next = 1'b0;
        end
        else if (text_in.token_start && text_in.token_length >= MIN_SPECIAL_LEN &&
                 b == MARK_OPEN && !text_in.token_end)
        begin
            hold_next = 1'b1;
        end
        else if (hold_next)
        begin
            hold_next = 1'b0;
            if (b == MARK_BAR)
                skip_next = !text_in.token_end;
            else
            begin
                e.p0   = CP_W'(MARK_OPEN);
                e.v0   = 1'b1;
                do_dec = 1'b1;
            end
        end
        else
        begin
            do_dec = 1'b1;
        end

        if (do_dec)
        begin
            if (bse_next != 2'd0)
            begin
                acc_next = {acc_next[CP_W-7:0], b[5:0]};
                bse_next = bse_next - 2'd1;
                if (bse_next == 2'd0)
                begin
                    if (!e.v0)
                    begin
                        e.p0 = acc_next;
                        e.v0 = 1'b1;
                    end
                    else
                    begin
                        e.p1 = acc_next;
                        e.v1 = 1'b1;
                    end
                    acc_next = '0;
                end
            end
            else if (b < LEAD_TWO)
            begin
                if (!e.v0)
                begin
                    e.p0 = CP_W'(b);
                    e.v0 = 1'b1;
                end
                else
                begin
                    e.p1 = CP_W'(b);
                    e.v1 = 1'b1;
                end
            end
            else
            begin
                if (b < LEAD_THREE)
                    n = 2'd1;
                else if (b < LEAD_FOUR)
                    n = 2'd2;
                else
                    n = 2'd3;
                bse_next = n;
                acc_next = CP_W'(b & (LEAD_MASK >> n));
            end

            // flush a partial sequence at token end
            if (text_in.token_end && bse_next != 2'd0)
            begin
                if (!e.v0)
                begin
                    e.p0 = acc_next;
                    e.v0 = 1'b1;
                end
                else
                begin
                    e.p1 = acc_next;
                    e.v1 = 1'b1;
                end
                bse_next = 2'd0;
                acc_next = '0;
            end
        end
    end

    assign push      = accept && (e.v0 || e.v1);
    assign push_data = e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            bse_reg  <= '0;
            skip_reg <= 1'b0;
            hold_reg <= 1'b0;
        end
        else if (accept)
        begin
            acc_reg  <= acc_next;
            bse_reg  <= bse_next;
            skip_reg <= skip_next;
            hold_reg <= hold_next;
        end
    end

    a_hold_skip_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(hold_reg && skip_reg))
        else $error("marker held while skipping a special token");

    a_hold_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg |-> bse_reg == 2'd0)
        else $error("marker held with a partial sequence pending");

endmodule

[hw/rtl/dtok_queue.sv]
module dtok_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dtok_pkg::entry_t  push_data,
    input  logic              pop,
    output dtok_pkg::entry_t  head,
    output dtok_pkg::q_stat_t q_stat
);
    import dtok_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    entry_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign q_stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_stat.avail = (cnt_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && q_stat.avail;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_ptr_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || cnt_reg == CNT_W'(DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

[hw/rtl/dtok_back.sv]
module dtok_back (
    input  logic              clk,
    input  logic              rst_n,
    input  dtok_pkg::entry_t  head,
    input  dtok_pkg::q_stat_t q_stat,
    output logic              pop,
    dtok_out_if.source        text_out
);
    import dtok_pkg::*;

    logic       phase_reg, phase_next;
    logic       out_vld_reg, out_vld_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       run_last_reg, run_last_next;
    logic       load_ok;
    logic       ok0;
    logic       ok1;
    unmap_t     m0;
    unmap_t     m1;

    assign m0      = unmap_point(head.p0);
    assign m1      = unmap_point(head.p1);
    assign ok0     = head.v0 && m0.ok;
    assign ok1     = head.v1 && m1.ok;
    assign load_ok = !out_vld_reg || text_out.ready;

    always_comb
    begin
        pop           = 1'b0;
        phase_next    = phase_reg;
        out_vld_next  = out_vld_reg && !text_out.ready;
        out_byte_next = out_byte_reg;
        run_last_next = run_last_reg;
        if (q_stat.avail)
        begin
            if (phase_reg)
            begin
                // second byte of a pair
                if (load_ok)
                begin
                    out_vld_next  = 1'b1;
                    out_byte_next = m1.raw;
                    run_last_next = 1'b1;
                    pop           = 1'b1;
                    phase_next    = 1'b0;
                end
            end
            else if (ok0 && ok1)
            begin
                if (load_ok)
                begin
                    out_vld_next  = 1'b1;
                    out_byte_next = m0.raw;
                    run_last_next = 1'b0;
                    phase_next    = 1'b1;
                end
            end
            else if (ok0 || ok1)
            begin
                if (load_ok)
                begin
                    out_vld_next  = 1'b1;
                    out_byte_next = ok0 ? m0.raw : m1.raw;
                    run_last_next = 1'b1;
                    pop           = 1'b1;
                end
            end
            else
            begin
                // nothing maps: drop the entry
                pop = 1'b1;
            end
        end
    end

    assign text_out.valid    = out_vld_reg;
    assign text_out.out_byte = out_byte_reg;
    assign text_out.run_last = run_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
    end

    a_phase_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> q_stat.avail)
        else $error("second byte pending without a queue entry");

    a_phase_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg && !$past(phase_reg)) |-> (out_vld_reg && !run_last_reg))
        else $error("first byte of a pair marked last");

endmodule

[hw/rtl/byte_level_token_detokenizer.sv]
// Path: an accepted input word goes into the queue, then its results are registered
//   onto text_out. Throughput: one input word per cycle unless the queue is full; one
//   result per cycle while text_out is ready, a word with two results giving them in turn;
//   the QUEUE_DEPTH entry queue between decoder and unmapper sets how long input rides stalls.
// Reset: rst_n clears the UTF-8 state, marker and skip flags, empties the queue and
//   drops any pending result.
module byte_level_token_detokenizer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    dtok_in_if.sink    text_in,
    dtok_out_if.source text_out
);
    import dtok_pkg::*;

    // front: framing, special-token skipping, UTF-8 assembly
    // back: inverse byte table, one output byte per cycle while text_out is ready
    logic    push;
    logic    pop;
    entry_t  push_data;
    entry_t  head;
    q_stat_t q_stat;

    dtok_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // decouple the two halves so each can stall on its own
    dtok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    dtok_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .text_out (text_out)
    );

endmodule

[dv/tb_byte_level_token_detokenizer.sv]
`timescale 1ns / 1ps

module tb_byte_level_token_detokenizer;
    import dtok_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } dec_result_t;

    logic clk;
    logic rst_n;

    dtok_in_if  text_in ();
    dtok_out_if text_out ();

    byte_level_token_detokenizer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .text_out (text_out)
    );

    // Free-running clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decoder state as the block is expected to hold it
    logic [CP_W-1:0] code_acc;
    logic [1:0]      trail_due;
    logic            skip_special;
    logic            hold_open;

    dec_result_t expected_bytes[$];   // decoded bytes still owed by the block
    dec_result_t word_bytes[$];       // bytes caused by the word being predicted
    logic [7:0]  token_text[$];       // token under construction for the sender

    int  errors;
    int  items_sent;
    int  bytes_seen;
    int  stall_left;
    bit  idle_on;

    task automatic report_mismatch(input string what);
        if (errors < 20)
            $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    // Append one byte to the token under construction
    task automatic add_text_byte(input logic [7:0] v);
        token_text.insert(token_text.size(), v);
    endtask

    // Inverse byte-to-unicode table: {mapped, raw byte}
    function automatic logic [8:0] byte_for_code(input logic [CP_W-1:0] cp);
        logic [CP_W-1:0] shifted;
        if ((cp >= 33 && cp <= 126) || (cp >= 161 && cp <= 172) || (cp >= 174 && cp <= 255))
            return {1'b1, cp[7:0]};
        if (cp >= 256 && cp <= 288)
            return {1'b1, cp[7:0]};
        if (cp >= 289 && cp <= 322)
        begin
            shifted = cp - 22'd289 + 22'd127;
            return {1'b1, shifted[7:0]};
        end
        if (cp == 323)
            return {1'b1, 8'd173};
        return 9'd0;
    endfunction

    task automatic put_code(input logic [CP_W-1:0] cp);
        logic [8:0]  m;
        dec_result_t r;
        m = byte_for_code(cp);
        if (word_bytes.size() < 2 && m[8])
        begin
            r.out_byte = m[7:0];
            r.run_last = 1'b0;
            word_bytes.insert(word_bytes.size(), r);
        end
    endtask

    task automatic flush_partial();
        if (trail_due != 0)
        begin
            put_code(code_acc);
            trail_due = 0;
            code_acc  = '0;
        end
    endtask

    task automatic decode_text_byte(input logic [7:0] b);
        logic [1:0] n;
        if (trail_due != 0)
        begin
            code_acc  = {code_acc[CP_W-7:0], b[5:0]};
            trail_due = trail_due - 2'd1;
            if (trail_due == 0)
            begin
                put_code(code_acc);
                code_acc = '0;
            end
        end
        else if (b < LEAD_TWO)
            put_code(CP_W'(b));
        else
        begin
            n = (b < LEAD_THREE) ? 2'd1 : ((b < LEAD_FOUR) ? 2'd2 : 2'd3);
            trail_due = n;
            code_acc  = CP_W'(b & (LEAD_MASK >> n));
        end
    endtask

    // Work out the bytes one accepted word causes and queue them
    task automatic predict_decode(input logic [7:0] b, input logic st, input logic en,
                                  input logic [7:0] len);
        word_bytes.delete();
        if (st)
        begin
            // a new token closes the previous one
            if (hold_open)
                put_code(CP_W'(MARK_OPEN));
            hold_open    = 1'b0;
            skip_special = 1'b0;
            flush_partial();
        end
        if (skip_special)
        begin
            if (en)
                skip_special = 1'b0;
        end
        else if (st && len >= MIN_SPECIAL_LEN && b == MARK_OPEN && !en)
            hold_open = 1'b1;
        else if (hold_open)
        begin
            hold_open = 1'b0;
            if (b == MARK_BAR)
                skip_special = !en;
            else
            begin
                put_code(CP_W'(MARK_OPEN));
                decode_text_byte(b);
                if (en)
                    flush_partial();
            end
        end
        else
        begin
            decode_text_byte(b);
            if (en)
                flush_partial();
        end
        if (word_bytes.size() > 0)
            word_bytes[word_bytes.size()-1].run_last = 1'b1;
        foreach (word_bytes[i])
            expected_bytes.insert(expected_bytes.size(), word_bytes[i]);
    endtask

    // Present one word, hold it until accepted, then predict its bytes
    task automatic send_word(input logic [7:0] b, input logic st, input logic en,
                             input logic [7:0] len);
        int gap;
        bit ready_now;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            text_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_in.valid        <= 1'b1;
        text_in.text_byte    <= b;
        text_in.token_start  <= st;
        text_in.token_end    <= en;
        text_in.token_length <= len;
        // ready comes from registered queue state: its mid-cycle value is the one
        // seen at the next rising edge
        forever
        begin
            @(negedge clk);
            ready_now = text_in.ready;
            @(posedge clk);
            if (ready_now)
                break;
        end
        predict_decode(b, st, en, len);
        items_sent++;
    endtask

    // Send token_text as one token; the marks can be left off to break framing
    task automatic send_token(input logic [7:0] len, input bit with_start, input bit with_end);
        int last;
        last = token_text.size() - 1;
        foreach (token_text[i])
            send_word(token_text[i], with_start && i == 0, with_end && i == last, len);
        token_text.delete();
    endtask

    function automatic logic [7:0] true_length();
        return (token_text.size() > 255) ? 8'd255 : 8'(token_text.size());
    endfunction

    task automatic add_code_point(input int cp);
        if (cp < 'h80)
            add_text_byte(8'(cp));
        else if (cp < 'h800)
        begin
            add_text_byte({3'b110, cp[10:6]});
            add_text_byte({2'b10, cp[5:0]});
        end
        else if (cp < 'h10000)
        begin
            add_text_byte({4'b1110, cp[15:12]});
            add_text_byte({2'b10, cp[11:6]});
            add_text_byte({2'b10, cp[5:0]});
        end
        else
        begin
            add_text_byte({5'b11110, cp[20:18]});
            add_text_byte({2'b10, cp[17:12]});
            add_text_byte({2'b10, cp[11:6]});
            add_text_byte({2'b10, cp[5:0]});
        end
    endtask

    // Stop sending until every owed byte has come, then let the pipe settle
    task automatic wait_drained();
        text_in.valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Receiver: while idling is on, drop ready at random and hold it low while stall_left counts down
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left     <= stall_left - 1;
            text_out.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left     <= $urandom_range(0, 4);
            text_out.ready <= 1'b0;
        end
        else
            text_out.ready <= 1'b1;
    end

    // Compare each accepted byte with the oldest one owed
    always @(posedge clk)
    begin
        dec_result_t want;
        if (rst_n && text_out.valid && text_out.ready)
        begin
            bytes_seen++;
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h", text_out.out_byte));
            else
            begin
                want = expected_bytes.pop_front();
                if (text_out.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              text_out.out_byte, want.out_byte));
                if (text_out.run_last !== want.run_last)
                    report_mismatch($sformatf("run_last %0b, want %0b",
                                              text_out.run_last, want.run_last));
            end
        end
    end

    // Plain bytes: unmapped extremes, printable range, lone four-byte lead
    task automatic test_plain_text();
        token_text = '{8'h00};
        send_token(8'd1, 1, 1);
        token_text = '{8'h7F};
        send_token(8'd1, 1, 1);
        token_text = '{8'h21, 8'h7E};
        send_token(8'd2, 1, 1);
        token_text = '{8'hFF};
        send_token(8'd255, 1, 1);
        wait_drained();
    endtask

    // Multi-byte sequences, complete and cut short at token end
    task automatic test_utf8_sequences();
        add_code_point(256);
        send_token(8'd2, 1, 1);
        add_code_point(323);
        send_token(8'd2, 1, 1);
        token_text = '{8'hF0, 8'h80, 8'h81, 8'hA1};
        send_token(8'd4, 1, 1);
        // partial code point at end is still mapped
        token_text = '{8'hE1, 8'h81};
        send_token(8'd2, 1, 1);
        // new start while a sequence is pending flushes it
        token_text = '{8'hE1, 8'h81};
        send_token(8'd3, 1, 0);
        token_text = '{8'h42};
        send_token(8'd1, 1, 1);
        wait_drained();
    endtask

    // Special-token skipping and the held marker
    task automatic test_special_tokens();
        token_text = '{MARK_OPEN, MARK_BAR, 8'h78, 8'h3E};
        send_token(8'd4, 1, 1);
        // held marker released by a new start: two bytes from one word
        token_text = '{MARK_OPEN};
        send_token(8'd4, 1, 0);
        token_text = '{8'h41};
        send_token(8'd1, 1, 1);
        // candidate that ends on its first byte decodes normally
        token_text = '{MARK_OPEN};
        send_token(8'd4, 1, 1);
        // marker then bar on the end byte drops both, no skipping
        token_text = '{MARK_OPEN, MARK_BAR};
        send_token(8'd4, 1, 1);
        // marker then another byte gives the marker back
        token_text = '{MARK_OPEN, 8'h62};
        send_token(8'd4, 1, 1);
        // length zero is too short for a special token
        token_text = '{MARK_OPEN, MARK_BAR};
        send_token(8'd0, 1, 1);
        wait_drained();
    endtask

    task automatic build_random_text(input int units);
        int kind;
        repeat (units)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
                add_code_point($urandom_range(0, 323));
            else if (kind < 75)
                add_code_point($urandom_range(0, 127));
            else if (kind < 85)
                add_code_point($urandom_range('h80, 'h7FF));
            else if (kind < 92)
                add_code_point($urandom_range('h800, 'hFFFF));
            else if (kind < 96)
                add_code_point($urandom_range('h10000, 'h1FFFFF));
            else
                add_text_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // One random token; mostly well formed, some broken framing and noise
    task automatic send_random_token();
        int         kind;
        int         cut;
        logic [7:0] len;
        kind = $urandom_range(0, 99);
        if (kind < 40)
            build_random_text($urandom_range(1, 6));
        else if (kind < 60)
        begin
            token_text = '{MARK_OPEN, MARK_BAR};
            build_random_text($urandom_range(0, 4));
            add_text_byte(MARK_BAR);
            add_text_byte(8'h3E);
        end
        else if (kind < 70)
        begin
            token_text = '{MARK_OPEN};
            if ($urandom_range(0, 1))
                add_text_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                                        : MARK_BAR);
            if ($urandom_range(0, 1))
                build_random_text($urandom_range(1, 3));
        end
        else if (kind < 85)
        begin
            // truncated multi-byte sequence at token end
            build_random_text($urandom_range(0, 2));
            add_code_point($urandom_range('h80, 'h1FFFFF));
            cut = $urandom_range(1, 3);
            while (cut > 0 && token_text.size() > 1)
            begin
                void'(token_text.pop_back());
                cut--;
            end
        end
        else if (kind < 93)
        begin
            // noise word with random marks
            send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            return;
        end
        else
            build_random_text($urandom_range(1, 4));

        len = true_length();
        case ($urandom_range(0, 19))
            0, 1:    len = 8'($urandom_range(0, 255));
            2:       len = 8'd255;
            3:       len = 8'd4;
            default: ;
        endcase
        if (kind >= 93)
            send_token(len, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
        else
            send_token(len, 1, $urandom_range(0, 11) != 0);
    endtask

    task automatic test_random_tokens();
        int stop_at;
        int next_pause;
        stop_at    = items_sent + 1400;
        next_pause = items_sent + 400;
        while (items_sent < stop_at)
        begin
            send_random_token();
            if (items_sent >= next_pause)
            begin
                wait_drained();
                next_pause = items_sent + 400;
            end
        end
        wait_drained();
    endtask

    // Back-to-back traffic with both sides always ready
    task automatic test_full_rate();
        int stop_at;
        idle_on = 1'b0;
        stop_at = items_sent + 300;
        while (items_sent < stop_at)
            send_random_token();
        text_in.valid <= 1'b0;
    endtask

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        text_in.valid        = 1'b0;
        text_in.text_byte    = 8'h00;
        text_in.token_start  = 1'b0;
        text_in.token_end    = 1'b0;
        text_in.token_length = 8'h00;
        text_out.ready       = 1'b0;
        stall_left           = 0;
        idle_on              = 1'b1;
        errors               = 0;
        items_sent           = 0;
        bytes_seen           = 0;
        code_acc             = '0;
        trail_due            = '0;
        skip_special         = 1'b0;
        hold_open            = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_text();
        test_utf8_sequences();
        test_special_tokens();
        test_random_tokens();
        test_full_rate();

        // drain, then give the pipe time to show any stray byte
        @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (expected_bytes.size() != 0)
            report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));

        $display("Covered %0d text words (plain, UTF-8, special and broken tokens),",
                 items_sent);
        $display("with %0d output bytes checked in order.", bytes_seen);
        $display("Mismatches counted: %0d", errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timeout waiting for the block");
        $display("Regression FAIL");
        $finish;
    end

endmodule
